[rtl/peq_pkg.sv]
`timescale 1ns / 1ps

package peq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned TYPE_BITS_DEF     = 4;
  localparam int unsigned PRIORITY_BITS_DEF = 2;

  localparam int unsigned TYPE_W  = 4;
  localparam int unsigned PRIO_W  = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DEPTH_W = 5;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_END,
    ST_SHIFT_INIT,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_EMIT_FAIL,
    ST_EMIT_PUSH,
    ST_EMIT_POP
  } peq_state_e;

  typedef struct packed {
    logic load;
    logic push_wr;
    logic rd;
    logic cmp;
    logic shift_init;
    logic wr_shift;
    logic pop_done;
    logic emit;
    logic emit_ok;
    logic emit_win;
  } peq_cmd_t;

  typedef struct packed {
    logic kind_pop;
    logic empty;
    logic full;
    logic rd_last;
    logic shift_done;
  } peq_stat_t;

endpackage

[rtl/priority_event_queue.sv]
`timescale 1ns / 1ps

// Bounded priority event queue. An item is taken when start is high and busy
// is low; every item yields exactly one result, shown for a single cycle with
// done_o high, and the receiver cannot stall it. A push, and a failed push or
// pop, goes from the decide state straight to its emit state. A pop of a queue
// holding n entries, whose winner sits at position w (0 = oldest), uses the
// single read port of the entry memory first to scan all n entries for the
// winner and then to move the n - 1 - w younger entries down one place. busy
// drops in the cycle the result is shown.

module priority_event_queue #(
  parameter int unsigned QUEUE_DEPTH   = peq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TYPE_BITS     = peq_pkg::TYPE_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = peq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic [peq_pkg::TYPE_W-1:0]   event_type_i,
  input  logic [peq_pkg::PRIO_W-1:0]   event_priority_i,
  input  logic [peq_pkg::TIME_W-1:0]   event_time_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [peq_pkg::TYPE_W-1:0]   popped_type_o,
  output logic [peq_pkg::PRIO_W-1:0]   popped_priority_o,
  output logic [peq_pkg::TIME_W-1:0]   popped_time_o,
  output logic [peq_pkg::DEPTH_W-1:0]  depth_o
);
  import peq_pkg::*;

  peq_cmd_t  cmd;
  peq_stat_t stat;

  peq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  peq_dpath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TYPE_BITS     (TYPE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .kind_i            (kind_i),
    .event_type_i      (event_type_i),
    .event_priority_i  (event_priority_i),
    .event_time_i      (event_time_i),
    .done_o            (done_o),
    .ok_o              (ok_o),
    .popped_type_o     (popped_type_o),
    .popped_priority_o (popped_priority_o),
    .popped_time_o     (popped_time_o),
    .depth_o           (depth_o)
  );

endmodule

[rtl/peq_ctrl.sv]
`timescale 1ns / 1ps

module peq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  peq_pkg::peq_stat_t stat_i,
  output peq_pkg::peq_cmd_t  cmd_o
);
  import peq_pkg::*;

  peq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (!stat_i.kind_pop && stat_i.full) begin
          state_d = ST_EMIT_FAIL;
        end else if (!stat_i.kind_pop) begin
          cmd_o.push_wr = 1'b1;
          state_d       = ST_EMIT_PUSH;
        end else if (stat_i.empty) begin
          state_d = ST_EMIT_FAIL;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd  = 1'b1;
        cmd_o.cmp = 1'b1;
        if (stat_i.rd_last) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_SHIFT_INIT;
      end
      ST_SHIFT_INIT: begin
        cmd_o.shift_init = 1'b1;
        state_d          = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.wr_shift = 1'b1;
        if (stat_i.shift_done) begin
          state_d = ST_SHIFT_END;
        end else begin
          cmd_o.rd = 1'b1;
        end
      end
      ST_SHIFT_END: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.pop_done = 1'b1;
        state_d        = ST_EMIT_POP;
      end
      ST_EMIT_FAIL: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_EMIT_PUSH: begin
        cmd_o.emit    = 1'b1;
        cmd_o.emit_ok = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_EMIT_POP: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_ok  = 1'b1;
        cmd_o.emit_win = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/peq_dpath.sv]
`timescale 1ns / 1ps

module peq_dpath #(
  parameter int unsigned QUEUE_DEPTH   = peq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TYPE_BITS     = peq_pkg::TYPE_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = peq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  peq_pkg::peq_cmd_t            cmd_i,
  output peq_pkg::peq_stat_t           stat_o,
  input  logic                         kind_i,
  input  logic [peq_pkg::TYPE_W-1:0]   event_type_i,
  input  logic [peq_pkg::PRIO_W-1:0]   event_priority_i,
  input  logic [peq_pkg::TIME_W-1:0]   event_time_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [peq_pkg::TYPE_W-1:0]   popped_type_o,
  output logic [peq_pkg::PRIO_W-1:0]   popped_priority_o,
  output logic [peq_pkg::TIME_W-1:0]   popped_time_o,
  output logic [peq_pkg::DEPTH_W-1:0]  depth_o
);
  import peq_pkg::*;

  localparam int unsigned TW = (TYPE_BITS < TYPE_W) ? TYPE_BITS : TYPE_W;
  localparam int unsigned PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
  localparam int unsigned EW = TW + PW + TIME_W;
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [EW-1:0] mem [QUEUE_DEPTH];

  logic          kind_q;
  logic [EW-1:0] item_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] wptr_q, wptr_d;
  logic [CW-1:0] ridx_q;
  logic          rv_q, rv_d;
  logic [EW-1:0] rdata_q;
  logic [CW-1:0] best_q;
  logic [PW-1:0] best_prio_q;
  logic [EW-1:0] win_q;
  logic          take_best;
  logic [PW-1:0] rprio;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic                done_q;
  logic                ok_q;
  logic [TYPE_W-1:0]   type_q;
  logic [PRIO_W-1:0]   prio_q;
  logic [TIME_W-1:0]   time_q;
  logic [DEPTH_W-1:0]  depth_q;

  assign rprio     = rdata_q[TIME_W +: PW];
  assign take_best = cmd_i.cmp && rv_q && ((ridx_q == '0) || (rprio > best_prio_q));

  assign stat_o.kind_pop   = (kind_q == KIND_POP);
  assign stat_o.empty      = (cnt_q == '0);
  assign stat_o.full       = (cnt_q >= CW'(QUEUE_DEPTH));
  assign stat_o.rd_last    = (ptr_q == CW'(cnt_q - CW'(1)));
  assign stat_o.shift_done = (ptr_q >= cnt_q);

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[AW-1:0];
    wdata = item_q;
    if (cmd_i.push_wr) begin
      we = 1'b1;
    end else if (cmd_i.wr_shift && rv_q) begin
      we    = 1'b1;
      waddr = wptr_q[AW-1:0];
      wdata = rdata_q;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    ptr_d  = ptr_q;
    wptr_d = wptr_q;
    rv_d   = 1'b0;
    if (cmd_i.push_wr) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.pop_done) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.load) begin
      ptr_d = '0;
    end
    if (cmd_i.shift_init) begin
      ptr_d  = best_q + CW'(1);
      wptr_d = best_q;
    end
    if (cmd_i.rd) begin
      ptr_d = ptr_q + CW'(1);
      rv_d  = 1'b1;
    end
    if (cmd_i.wr_shift && rv_q) begin
      wptr_d = wptr_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[ptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rv_q   <= 1'b0;
      done_q <= 1'b0;
      kind_q <= KIND_PUSH;
    end else begin
      cnt_q  <= cnt_d;
      rv_q   <= rv_d;
      done_q <= cmd_i.emit;
      if (cmd_i.load) begin
        kind_q <= kind_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    wptr_q <= wptr_d;
    if (cmd_i.rd) begin
      ridx_q <= ptr_q;
    end
    if (cmd_i.load) begin
      item_q <= {TW'(event_type_i), PW'(event_priority_i), event_time_i};
    end
    if (take_best) begin
      best_q      <= ridx_q;
      best_prio_q <= rprio;
      win_q       <= rdata_q;
    end
    if (cmd_i.emit) begin
      ok_q    <= cmd_i.emit_ok;
      type_q  <= cmd_i.emit_win ? TYPE_W'(win_q[TIME_W+PW +: TW]) : '0;
      prio_q  <= cmd_i.emit_win ? PRIO_W'(win_q[TIME_W +: PW]) : '0;
      time_q  <= cmd_i.emit_win ? win_q[TIME_W-1:0] : '0;
      depth_q <= DEPTH_W'(cnt_q);
    end
  end

  assign done_o            = done_q;
  assign ok_o              = ok_q;
  assign popped_type_o     = type_q;
  assign popped_priority_o = prio_q;
  assign popped_time_o     = time_q;
  assign depth_o           = depth_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_wr |-> !stat_o.full)
    else $error("push written into a full queue");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_done |=> cnt_q == CW'($past(cnt_q) - CW'(1)))
    else $error("pop did not decrement fill count");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (popped_time_o == '0 && popped_type_o == '0))
    else $error("failed item carries popped data");

endmodule
